// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// implication checked in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/omni3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni3_pkg
// Widths, register indexes and beat types of the omni wheel speed pipeline.
// ----------------------------------------------------------------------------
package omni3_pkg;

    localparam int IN_BITS    = 16;
    localparam int R_BITS     = 10;
    localparam int LIM_BITS   = 15;
    localparam int CFG_BITS   = 15;
    localparam int IDX_BITS   = 2;
    localparam int W_BITS     = 18;   // raw wheel speed, |w| <= 52946
    localparam int MAG_BITS   = 16;
    localparam int QUO_BITS   = 15;   // scaled magnitude never exceeds the limit
    localparam int PROD_BITS  = MAG_BITS + LIM_BITS;
    localparam int NUM_WHEELS = 3;

    localparam logic [15:0] SIN60_Q15 = 16'd28378;

    localparam logic [R_BITS-1:0]   R_RESET     = 10'd150;
    localparam logic [LIM_BITS-1:0] LIMIT_RESET = 15'd1000;

    localparam logic [IDX_BITS-1:0] REG_CENTER = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_LIMIT  = 2'd1;

    typedef logic signed [W_BITS-1:0] wheel_t;
    typedef logic [MAG_BITS-1:0]      mag_t;

    typedef struct packed {
        wheel_t [NUM_WHEELS-1:0] w;
    } kin_beat_t;

    typedef struct packed {
        logic                                 scaled;
        logic [NUM_WHEELS-1:0]                neg;
        wheel_t [NUM_WHEELS-1:0]              w;
        mag_t                                 mx;
        logic [NUM_WHEELS-1:0][MAG_BITS-1:0]  rem;
        logic [NUM_WHEELS-1:0][QUO_BITS-1:0]  low;
        logic [NUM_WHEELS-1:0][QUO_BITS-1:0]  quo;
    } div_beat_t;

endpackage

// ===== rtl/core/omni3_kin.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni3_kin
// Two-stage inverse kinematics: products, then truncating shifts and sums.
// ----------------------------------------------------------------------------
module omni3_kin (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [omni3_pkg::IN_BITS-1:0]   vel_x,
    input  logic signed [omni3_pkg::IN_BITS-1:0]   vel_y,
    input  logic signed [omni3_pkg::IN_BITS-1:0]   yaw_rate,
    input  logic [omni3_pkg::R_BITS-1:0]           center,
    output logic                                   out_valid,
    output omni3_pkg::kin_beat_t                   out_beat
);

    logic                v1_reg;
    logic signed [31:0]  psx_reg, psx_next;
    logic signed [26:0]  prot_reg, prot_next;
    logic signed [15:0]  half_reg, half_next;
    logic signed [15:0]  vy_reg;
    logic signed [16:0]  vy_biased;

    logic                   v2_reg;
    omni3_pkg::kin_beat_t   beat_reg, beat_next;
    logic signed [31:0]     sx_full;
    logic signed [26:0]     rot_full;
    omni3_pkg::wheel_t      sx_w, rot_w, half_w, vy_w;

    // stage 1: multiply, halve vy toward zero
    always_comb
    begin
        psx_next  = vel_x * $signed(omni3_pkg::SIN60_Q15);
        prot_next = 27'(yaw_rate) * 27'($signed({1'b0, center}));
        vy_biased = 17'(vel_y) + $signed({16'd0, vel_y[15]});
        half_next = 16'(vy_biased >>> 1);
    end

    // stage 2: divide by powers of two toward zero, then sum
    always_comb
    begin
        sx_full  = (psx_reg + $signed({17'd0, {15{psx_reg[31]}}})) >>> 15;
        rot_full = (prot_reg + $signed({15'd0, {12{prot_reg[26]}}})) >>> 12;
        sx_w     = omni3_pkg::wheel_t'(sx_full);
        rot_w    = omni3_pkg::wheel_t'(rot_full);
        half_w   = omni3_pkg::wheel_t'(half_reg);
        vy_w     = omni3_pkg::wheel_t'(vy_reg);
        beat_next.w[0] = half_w + sx_w + rot_w;
        beat_next.w[1] = half_w - sx_w + rot_w;
        beat_next.w[2] = rot_w - vy_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        psx_reg  <= psx_next;
        prot_reg <= prot_next;
        half_reg <= half_next;
        vy_reg   <= vel_y;
        beat_reg <= beat_next;
    end

    assign out_valid = v2_reg;
    assign out_beat  = beat_reg;

endmodule

// ===== rtl/core/omni3_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni3_norm
// Magnitudes, largest magnitude and limit test, then magnitude times limit.
// ----------------------------------------------------------------------------
module omni3_norm (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  omni3_pkg::kin_beat_t                 in_beat,
    input  logic [omni3_pkg::LIM_BITS-1:0]       limit,
    output logic                                 out_valid,
    output omni3_pkg::div_beat_t                 out_beat
);

    localparam int NW = omni3_pkg::NUM_WHEELS;

    logic                                 v3_reg;
    omni3_pkg::mag_t [NW-1:0]             mag_reg, mag_next;
    logic [NW-1:0]                        neg_reg, neg_next;
    omni3_pkg::wheel_t [NW-1:0]           w_reg;
    omni3_pkg::mag_t                      mx_reg, mx_next;
    logic                                 scaled_reg, scaled_next;
    omni3_pkg::mag_t                      m01;
    omni3_pkg::wheel_t                    absv;

    logic                                 v4_reg;
    omni3_pkg::div_beat_t                 beat_reg, beat_next;
    logic [omni3_pkg::PROD_BITS-1:0]      prod;

    // stage 3: magnitudes and largest one
    always_comb
    begin
        for (int i = 0; i < NW; i++)
        begin
            neg_next[i] = in_beat.w[i][omni3_pkg::W_BITS-1];
            absv        = neg_next[i] ? -$signed(in_beat.w[i]) : $signed(in_beat.w[i]);
            mag_next[i] = absv[omni3_pkg::MAG_BITS-1:0];
        end
        m01         = (mag_next[0] > mag_next[1]) ? mag_next[0] : mag_next[1];
        mx_next     = (m01 > mag_next[2]) ? m01 : mag_next[2];
        scaled_next = mx_next > omni3_pkg::mag_t'(limit);
    end

    // stage 4: numerator of the scale division, split into head and tail bits
    always_comb
    begin
        beat_next.scaled = scaled_reg;
        beat_next.neg    = neg_reg;
        beat_next.w      = w_reg;
        beat_next.mx     = mx_reg;
        for (int i = 0; i < NW; i++)
        begin
            prod = omni3_pkg::PROD_BITS'(mag_reg[i]) * omni3_pkg::PROD_BITS'(limit);
            beat_next.rem[i] = prod[omni3_pkg::PROD_BITS-1:omni3_pkg::QUO_BITS];
            beat_next.low[i] = prod[omni3_pkg::QUO_BITS-1:0];
            beat_next.quo[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        w_reg      <= in_beat.w;
        mx_reg     <= mx_next;
        scaled_reg <= scaled_next;
        beat_reg   <= beat_next;
    end

    assign out_valid = v4_reg;
    assign out_beat  = beat_reg;

endmodule

// ===== rtl/core/omni3_div_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni3_div_step
// One restoring-division stage: one quotient bit for each of the three lanes.
// ----------------------------------------------------------------------------
module omni3_div_step (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  omni3_pkg::div_beat_t    in_beat,
    output logic                    out_valid,
    output omni3_pkg::div_beat_t    out_beat
);

    localparam int NW = omni3_pkg::NUM_WHEELS;
    localparam int QB = omni3_pkg::QUO_BITS;
    localparam int MB = omni3_pkg::MAG_BITS;

    logic                   valid_reg;
    omni3_pkg::div_beat_t   beat_reg, beat_next;
    logic [MB:0]            trial;
    logic [MB:0]            diff;

    always_comb
    begin
        beat_next = in_beat;
        for (int i = 0; i < NW; i++)
        begin
            // bring down the next numerator bit and try the subtract
            trial = {in_beat.rem[i], in_beat.low[i][QB-1]};
            diff  = trial - {1'b0, in_beat.mx};
            if (trial >= {1'b0, in_beat.mx})
            begin
                beat_next.rem[i] = diff[MB-1:0];
                beat_next.quo[i] = {in_beat.quo[i][QB-2:0], 1'b1};
            end
            else
            begin
                beat_next.rem[i] = trial[MB-1:0];
                beat_next.quo[i] = {in_beat.quo[i][QB-2:0], 1'b0};
            end
            beat_next.low[i] = {in_beat.low[i][QB-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ===== rtl/core/omni3_wheel_speed_desaturate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni3_wheel_speed_desaturate
// Three-wheel omni inverse kinematics with proportional limit scaling.
// ----------------------------------------------------------------------------
// A command is taken on any cycle with start high; busy never rises, so one
// command per clock is sustained. Each result appears with done high for
// exactly one cycle; the receiver cannot stall and must take it then. The
// scaling divider resolves one quotient bit per stage over 15 stages, behind
// two kinematics stages, two magnitude/multiply stages and the output
// register. The configuration port is always ready; write it only while no
// command is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module omni3_wheel_speed_desaturate #(
    parameter int SPEED_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [omni3_pkg::IN_BITS-1:0]  vel_x,
    input  logic signed [omni3_pkg::IN_BITS-1:0]  vel_y,
    input  logic signed [omni3_pkg::IN_BITS-1:0]  yaw_rate,
    output logic                                  done,
    output logic signed [SPEED_BITS-1:0]          wheel_one,
    output logic signed [SPEED_BITS-1:0]          wheel_two,
    output logic signed [SPEED_BITS-1:0]          wheel_three,
    output logic                                  was_scaled,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [omni3_pkg::IDX_BITS-1:0]        cfg_index,
    input  logic [omni3_pkg::CFG_BITS-1:0]        cfg_data
);

    localparam int NW      = omni3_pkg::NUM_WHEELS;
    localparam int QB      = omni3_pkg::QUO_BITS;
    localparam int SAT_W   = ((SPEED_BITS > omni3_pkg::W_BITS) ?
                              SPEED_BITS : omni3_pkg::W_BITS) + 1;
    localparam logic signed [SAT_W-1:0] SPEED_TOP =
        SAT_W'((64'd1 << (SPEED_BITS - 1)) - 64'd1);
    localparam logic signed [SAT_W-1:0] SPEED_BOT = -SPEED_TOP;
    localparam int LATENCY = 5 + QB;

    // configuration
    logic [omni3_pkg::R_BITS-1:0]   center_reg;
    logic [omni3_pkg::LIM_BITS-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= omni3_pkg::R_RESET;
            limit_reg  <= omni3_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                omni3_pkg::REG_CENTER: center_reg <= cfg_data[omni3_pkg::R_BITS-1:0];
                omni3_pkg::REG_LIMIT:  limit_reg  <= cfg_data[omni3_pkg::LIM_BITS-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // kinematics and normalization front end
    logic                   kin_valid;
    omni3_pkg::kin_beat_t   kin_beat;
    logic                   chain_valid [0:QB];
    omni3_pkg::div_beat_t   chain_beat  [0:QB];

    omni3_kin u_kin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .yaw_rate  (yaw_rate),
        .center    (center_reg),
        .out_valid (kin_valid),
        .out_beat  (kin_beat)
    );

    omni3_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (kin_valid),
        .in_beat   (kin_beat),
        .limit     (limit_reg),
        .out_valid (chain_valid[0]),
        .out_beat  (chain_beat[0])
    );

    // scaling divider, one quotient bit per stage
    genvar s;
    generate
        for (s = 0; s < QB; s++)
        begin : g_div
            omni3_div_step u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (chain_valid[s]),
                .in_beat   (chain_beat[s]),
                .out_valid (chain_valid[s+1]),
                .out_beat  (chain_beat[s+1])
            );
        end
    endgenerate

    // output stage: restore sign, pick scaled or raw, saturate to port width
    omni3_pkg::div_beat_t              fin;
    logic signed [SAT_W-1:0]           val [NW];
    logic signed [SPEED_BITS-1:0]      spd_next [NW];
    logic signed [SPEED_BITS-1:0]      spd_reg  [NW];
    logic                              done_reg;
    logic                              scaled_reg;

    assign fin = chain_beat[QB];

    always_comb
    begin
        for (int i = 0; i < NW; i++)
        begin
            if (fin.scaled)
            begin
                val[i] = $signed({{(SAT_W-QB){1'b0}}, fin.quo[i]});
                if (fin.neg[i])
                    val[i] = -val[i];
            end
            else
            begin
                val[i] = SAT_W'($signed(fin.w[i]));
            end
            if (val[i] > SPEED_TOP)
                spd_next[i] = SPEED_TOP[SPEED_BITS-1:0];
            else if (val[i] < SPEED_BOT)
                spd_next[i] = SPEED_BOT[SPEED_BITS-1:0];
            else
                spd_next[i] = val[i][SPEED_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain_valid[QB];
    end

    always_ff @(posedge clk)
    begin
        spd_reg    <= spd_next;
        scaled_reg <= fin.scaled;
    end

    assign done        = done_reg;
    assign wheel_one   = spd_reg[0];
    assign wheel_two   = spd_reg[1];
    assign wheel_three = spd_reg[2];
    assign was_scaled  = scaled_reg;

    // checks
    logic signed [SAT_W-1:0] lim_wide;
    assign lim_wide = $signed({{(SAT_W-omni3_pkg::LIM_BITS){1'b0}}, limit_reg});

    `ASSERT_IMPL(a_latency, start && !busy, ##LATENCY done)
    `ASSERT_IMPL(a_no_orphan, done, $past(start && !busy, LATENCY))
    `ASSERT_IMPL(a_scaled_within_limit, done && was_scaled,
        ($signed(wheel_one) <= lim_wide) && ($signed(wheel_one) >= -lim_wide) &&
        ($signed(wheel_three) <= lim_wide) && ($signed(wheel_three) >= -lim_wide))
    `ASSERT_IMPL(a_saturated, done,
        ($signed(wheel_two) >= SPEED_BOT) && ($signed(wheel_one) >= SPEED_BOT) &&
        ($signed(wheel_three) >= SPEED_BOT))

endmodule
